// File: design/sparse_multiclass_linear_scorer_unit_assert.svh
// assertion macros for the sparse multiclass linear scorer
`ifndef SPARSE_MULTICLASS_LINEAR_SCORER_UNIT_ASSERT_SVH
`define SPARSE_MULTICLASS_LINEAR_SCORER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define SMLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SMLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SMLS_ASSERT(lbl, prop, msg)
`define SMLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/smls_pkg.sv
// shared constants and types of the sparse multiclass linear scorer
`default_nettype none
package smls_pkg;

    localparam int MAX_CLASSES  = 16;
    localparam int MAX_FEATURES = 4096;
    localparam int WEIGHT_DEPTH = 65536;

    // fixed field widths
    localparam int CMD_W   = 1;
    localparam int WADDR_W = 16;
    localparam int W_W     = 24;
    localparam int FID_W   = 12;
    localparam int F_W     = 16;
    localparam int LBL_W   = 4;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = W_W + F_W;
    localparam int BSC_W   = 47;
    localparam int NC_W    = 5;
    localparam int NF_W    = 13;

    // derived widths
    localparam int RADDR_W = $clog2(WEIGHT_DEPTH);
    localparam int ASUM_W  = $clog2(MAX_FEATURES * MAX_CLASSES + MAX_CLASSES) + 1;
    localparam int CLS_W   = $clog2(MAX_CLASSES);

    localparam int BIAS_SHIFT = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 1'b1;

    // item commands
    localparam logic [CMD_W-1:0] CMD_WRITE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FEATURE = 1'b1;

    // tag that follows a weight read down the pipe
    typedef struct packed {
        logic             valid;
        logic             bias;
        logic             oob;
        logic [CLS_W-1:0] y;
    } t_tag;

    // control of the best-class scan
    typedef struct packed {
        logic             clr;
        logic             step;
        logic [CLS_W-1:0] y;
    } t_scan;

endpackage
`default_nettype wire

// File: design/smls_wram.sv
// weight memory, one write port and one registered read port
`default_nettype none
module smls_wram (
    input  wire                                  i_clk,
    input  wire                                  i_we,
    input  wire  [smls_pkg::RADDR_W-1:0]         i_waddr,
    input  wire  signed [smls_pkg::W_W-1:0]      i_wdata,
    input  wire                                  i_re,
    input  wire  [smls_pkg::RADDR_W-1:0]         i_raddr,
    output logic signed [smls_pkg::W_W-1:0]      o_rdata
);

    logic signed [smls_pkg::W_W-1:0] r_mem [0:smls_pkg::WEIGHT_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/smls_acc.sv
// multiply stage, score accumulators with saturation, best-class scan
`default_nettype none
module smls_acc (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire  smls_pkg::t_tag                   i_tag,
    input  wire  signed [smls_pkg::W_W-1:0]        i_weight,
    input  wire  signed [smls_pkg::F_W-1:0]        i_fval,
    input  wire  smls_pkg::t_scan                  i_scan,
    input  wire  [smls_pkg::CLS_W-1:0]             i_km1,
    output logic signed [smls_pkg::ACC_W-1:0]      o_best,
    output logic [smls_pkg::CLS_W-1:0]             o_best_class,
    output logic signed [smls_pkg::ACC_W-1:0]      o_first
);

    localparam int AW = smls_pkg::ACC_W;

    smls_pkg::t_tag             r_s2;
    logic signed [AW-1:0]       r_prod;
    logic signed [AW-1:0]       r_score [0:smls_pkg::MAX_CLASSES-2];
    logic signed [AW-1:0]       r_best;
    logic [smls_pkg::CLS_W-1:0] r_best_class;

    logic signed [smls_pkg::PROD_W-1:0] mul;
    logic signed [AW-1:0]               bias_ext;
    logic [smls_pkg::CLS_W-1:0]         rd_y;
    logic signed [AW-1:0]               sel;
    logic signed [AW:0]                 sum;
    logic signed [AW-1:0]               sat;

    assign mul      = i_weight * i_fval;
    assign bias_ext = AW'($signed({i_weight, {smls_pkg::BIAS_SHIFT{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.bias) begin
            r_prod <= bias_ext;
        end else if (i_tag.oob) begin
            r_prod <= '0;
        end else begin
            r_prod <= AW'(mul);
        end
    end

    // single read address: scan and accumulate never overlap
    assign rd_y = i_scan.step ? i_scan.y : r_s2.y;
    assign sel  = r_score[rd_y];
    assign sum  = {sel[AW-1], sel} + {r_prod[AW-1], r_prod};

    always_comb begin
        if (sum[AW] != sum[AW-1]) begin
            sat = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            sat = sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < smls_pkg::MAX_CLASSES - 1; i++) begin
                r_score[i] <= '0;
            end
        end else if (r_s2.valid) begin
            r_score[r_s2.y] <= r_s2.bias ? r_prod : sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.clr) begin
            r_best       <= '0;
            r_best_class <= i_km1;
        end else if (i_scan.step && (sel > r_best)) begin
            r_best       <= sel;
            r_best_class <= i_scan.y;
        end
    end

    assign o_best       = r_best;
    assign o_best_class = r_best_class;
    assign o_first      = r_score[0];

endmodule
`default_nettype wire

// File: design/sparse_multiclass_linear_scorer_unit.sv
// top level of the sparse multiclass linear scorer: sequencer, config and result register
// A weight-write item (command 0) stores one word of the weight memory: K-1 biases at
// 0..K-2, then K-1 rows of num_features weights. A feature item (command 1) is worked
// one at a time through the single read port of the weight memory: the first feature
// of an instance loads the K-1 biases, every feature with an id below num_features
// reads K-1 weights into a multiply stage and a saturating accumulate stage, a drain
// state lets that pipe empty, and the feature marked last adds a best-class scan over
// the K-1 scores and a load of the result register. The result register lets the
// next item in while a result waits, but an instance end stalls until the previous
// result is taken. Weights never written read as undefined values; there is no
// clearing pass.
`default_nettype none
`include "sparse_multiclass_linear_scorer_unit_assert.svh"
module sparse_multiclass_linear_scorer_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item input
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [smls_pkg::CMD_W-1:0]           i_command,
    input  wire  [smls_pkg::WADDR_W-1:0]         i_weight_address,
    input  wire  signed [smls_pkg::W_W-1:0]      i_weight_value,
    input  wire  [smls_pkg::FID_W-1:0]           i_feature_id,
    input  wire  signed [smls_pkg::F_W-1:0]      i_feature_value,
    input  wire                                  i_last,
    input  wire  [smls_pkg::LBL_W-1:0]           i_ref_label,
    // result output
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [smls_pkg::LBL_W-1:0]           o_best_class,
    output logic [smls_pkg::BSC_W-1:0]           o_best_score,
    output logic signed [smls_pkg::ACC_W-1:0]    o_first_score,
    output logic                                 o_label_match,
    // configuration writes
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [smls_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [smls_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW = smls_pkg::CLS_W;
    localparam int SW = smls_pkg::ASUM_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BIAS  = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers, kept raw and clamped where used
    logic [smls_pkg::NC_W-1:0] r_num_classes;
    logic [smls_pkg::NF_W-1:0] r_num_features;

    // per-feature context
    logic [CW-1:0]                  r_y, n_y;
    logic [SW-1:0]                  r_addr, n_addr;
    logic [CW-1:0]                  r_km1, n_km1;
    logic [smls_pkg::NF_W-1:0]      r_p, n_p;
    logic signed [smls_pkg::F_W-1:0] r_fval;
    logic                           r_fid_ok;
    logic                           r_last;
    logic [smls_pkg::LBL_W-1:0]     r_label;
    logic                           r_in_inst, n_in_inst;
    logic                           r_drain, n_drain;
    smls_pkg::t_tag                 r_s1, issue;

    // result register
    logic                              r_o_valid;
    logic [smls_pkg::LBL_W-1:0]        r_o_best_class;
    logic [smls_pkg::BSC_W-1:0]        r_o_best_score;
    logic signed [smls_pkg::ACC_W-1:0] r_o_first_score;
    logic                              r_o_label_match;

    logic                               in_acc;
    logic                               out_free;
    logic [CW-1:0]                      km1_eff;
    logic [smls_pkg::NF_W-1:0]          p_eff;
    logic                               wr_en;
    logic [smls_pkg::RADDR_W-1:0]       rd_addr;
    logic signed [smls_pkg::W_W-1:0]    rd_data;
    smls_pkg::t_scan                    scan;
    logic signed [smls_pkg::ACC_W-1:0]  best;
    logic [CW-1:0]                      best_class;
    logic signed [smls_pkg::ACC_W-1:0]  first;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;

    // clamp class and feature counts to their legal ranges
    always_comb begin
        if (r_num_classes < smls_pkg::NC_W'(2)) begin
            km1_eff = CW'(1);
        end else if (r_num_classes > smls_pkg::NC_W'(smls_pkg::MAX_CLASSES)) begin
            km1_eff = CW'(smls_pkg::MAX_CLASSES - 1);
        end else begin
            km1_eff = CW'(r_num_classes - smls_pkg::NC_W'(1));
        end
        if (r_num_features == '0) begin
            p_eff = smls_pkg::NF_W'(1);
        end else if (r_num_features > smls_pkg::NF_W'(smls_pkg::MAX_FEATURES)) begin
            p_eff = smls_pkg::NF_W'(smls_pkg::MAX_FEATURES);
        end else begin
            p_eff = r_num_features;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes  <= smls_pkg::NC_W'(2);
            r_num_features <= smls_pkg::NF_W'(smls_pkg::MAX_FEATURES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                smls_pkg::CFG_NUM_CLASSES: begin
                    r_num_classes <= i_cfg_data[smls_pkg::NC_W-1:0];
                end
                smls_pkg::CFG_NUM_FEATURES: begin
                    r_num_features <= i_cfg_data[smls_pkg::NF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign wr_en = in_acc && (i_command == smls_pkg::CMD_WRITE);

    // sequencer: bias pass, weight pass, drain, scan, result
    always_comb begin
        n_state   = r_state;
        n_y       = r_y;
        n_addr    = r_addr;
        n_km1     = r_km1;
        n_p       = r_p;
        n_in_inst = r_in_inst;
        n_drain   = r_drain;
        issue     = '0;
        rd_addr   = '0;
        scan      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_command == smls_pkg::CMD_FEATURE)) begin
                    n_km1  = km1_eff;
                    n_p    = p_eff;
                    n_y    = '0;
                    n_addr = SW'(i_feature_id) + SW'(km1_eff);
                    if (!r_in_inst) begin
                        n_state   = ST_BIAS;
                        n_in_inst = 1'b1;
                    end else if (smls_pkg::NF_W'(i_feature_id) < p_eff) begin
                        n_state = ST_MAC;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_BIAS: begin
                issue.valid = 1'b1;
                issue.bias  = 1'b1;
                issue.y     = r_y;
                rd_addr     = smls_pkg::RADDR_W'(r_y);
                if (r_y == r_km1 - CW'(1)) begin
                    n_y     = '0;
                    n_state = r_fid_ok ? ST_MAC : ST_DRAIN;
                end else begin
                    n_y = r_y + CW'(1);
                end
            end
            ST_MAC: begin
                issue.valid = 1'b1;
                issue.oob   = (r_addr >= SW'(smls_pkg::WEIGHT_DEPTH));
                issue.y     = r_y;
                rd_addr     = r_addr[smls_pkg::RADDR_W-1:0];
                n_addr      = r_addr + SW'(r_p);
                if (r_y == r_km1 - CW'(1)) begin
                    n_y     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_y = r_y + CW'(1);
                end
            end
            ST_DRAIN: begin
                // held through r_drain until the last accumulate has landed
                n_drain = !r_drain;
                if (r_drain) begin
                    if (r_last) begin
                        scan.clr  = 1'b1;
                        n_y       = '0;
                        n_in_inst = 1'b0;
                        n_state   = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                scan.step = 1'b1;
                scan.y    = r_y;
                if (r_y == r_km1 - CW'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_y = r_y + CW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_inst <= 1'b0;
            r_drain   <= 1'b0;
            r_s1      <= '0;
        end else begin
            r_state   <= n_state;
            r_in_inst <= n_in_inst;
            r_drain   <= n_drain;
            r_s1      <= issue;
        end
    end

    // item context, no reset needed
    always_ff @(posedge i_clk) begin
        r_y    <= n_y;
        r_addr <= n_addr;
        r_km1  <= n_km1;
        r_p    <= n_p;
        if (in_acc && (i_command == smls_pkg::CMD_FEATURE)) begin
            r_fval   <= i_feature_value;
            r_fid_ok <= (smls_pkg::NF_W'(i_feature_id) < p_eff);
            r_last   <= i_last;
            r_label  <= i_ref_label;
        end
    end

    smls_wram u_wram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (smls_pkg::RADDR_W'(i_weight_address)),
        .i_wdata (i_weight_value),
        .i_re    (issue.valid),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    smls_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (r_s1),
        .i_weight     (rd_data),
        .i_fval       (r_fval),
        .i_scan       (scan),
        .i_km1        (r_km1),
        .o_best       (best),
        .o_best_class (best_class),
        .o_first      (first)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_o_best_class  <= smls_pkg::LBL_W'(best_class);
            r_o_best_score  <= best[smls_pkg::BSC_W-1:0];
            r_o_first_score <= first;
            r_o_label_match <= (smls_pkg::LBL_W'(best_class) == r_label);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_best_class  = r_o_best_class;
    assign o_best_score  = r_o_best_score;
    assign o_first_score = r_o_first_score;
    assign o_label_match = r_o_label_match;

    // scan reads scores only after the pipe has drained
    `SMLS_ASSERT(a_scan_drained, (r_state == ST_SCAN) |-> !r_s1.valid, "scan with read in flight")
    // a weight write never lands while weight reads are in flight
    `SMLS_ASSERT(a_write_quiet, wr_en |-> !r_s1.valid, "weight write during read pass")
    // a new result only comes out of the result state
    `SMLS_ASSERT(a_result_src, $rose(o_valid) |-> $past(r_state == ST_DONE), "stray result")
    // reset leaves no result and an open input
    `SMLS_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_valid && o_ready, "reset not clean")

endmodule
`default_nettype wire
